FILE: src/chtqp_pkg.sv
// Shared constants, types and codes of the counting hash table.
`default_nettype none
package chtqp_pkg;

  localparam int IDX_W      = 12;
  localparam int TABLE_SIZE = 1 << IDX_W;
  localparam int OCC_W      = IDX_W + 1;
  localparam int KEY_W      = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_W      = 13;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 13'd3072;

  localparam logic [31:0] MIX_XOR = 32'd61;
  localparam logic [31:0] MIX_MUL = 32'h27d4eb2d;

  localparam logic [1:0] REQ_INC   = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RESERVED = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } entry_t;

endpackage
`default_nettype wire

FILE: src/chtqp_if.sv
// Request, response and configuration channel interfaces.
`default_nettype none
interface chtqp_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         req_type;
  logic signed [chtqp_pkg::KEY_W-1:0] key;
  logic [chtqp_pkg::CNT_W-1:0]        new_count;
  modport source (output valid, req_type, key, new_count, input ready);
  modport sink (input valid, req_type, key, new_count, output ready);
endinterface

interface chtqp_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [chtqp_pkg::CNT_W-1:0] count_out;
  logic                        is_new;
  logic [1:0]                  status;
  modport source (output valid, count_out, is_new, status, input ready);
  modport sink (input valid, count_out, is_new, status, output ready);
endinterface

interface chtqp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [chtqp_pkg::CFG_W-1:0] max_entries;
  modport source (output valid, max_entries, input ready);
  modport sink (input valid, max_entries, output ready);
endinterface
`default_nettype wire

FILE: src/chtqp_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none
module chtqp_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/chtqp_hash.sv
// Two-stage 32-bit integer mix of the key.
`default_nettype none
module chtqp_hash (
  input  wire logic        clk,
  input  wire logic [31:0] key,
  output      logic [31:0] hash
);

  logic [31:0] a1, a2, a3;
  logic [31:0] stage1;
  logic [31:0] prod;

  always_comb begin
    a1 = (key ^ chtqp_pkg::MIX_XOR) ^ (key >> 16);
    a2 = a1 + (a1 << 3);
    a3 = a2 ^ (a2 >> 4);
  end

  always_ff @(posedge clk) begin
    stage1 <= a3;
    prod   <= 32'(stage1 * chtqp_pkg::MIX_MUL);
  end

  assign hash = prod ^ (prod >> 15);

endmodule
`default_nettype wire

FILE: src/counting_hash_table_quadratic_probe.sv
// Top level: probe sequencer, occupancy and response register of the counting hash table.
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  req_type, key, new_count
//   rsp      out  valid/ready  count_out, is_new, status
//   cfg      in   valid/ready  max_entries
//
// An item passes S_MIX, S_MUL and S_HASH, then S_READ and S_CHECK for each slot read
// (one RAM read and check per probe); a reserved key goes from S_IDLE straight to S_DONE.
// After reset a clearing pass writes all TABLE_SIZE (4096) slots; req.ready stays low.
// req is taken again while a finished response still waits on rsp.
// cfg is always ready.
`default_nettype none
module counting_hash_table_quadratic_probe (
  input wire logic       clk,
  input wire logic       rst,
  chtqp_req_if.sink      req,
  chtqp_rsp_if.source    rsp,
  chtqp_cfg_if.sink      cfg
);

  localparam int IDX_W = chtqp_pkg::IDX_W;
  localparam int OCC_W = chtqp_pkg::OCC_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MIX, S_MUL, S_HASH, S_READ, S_CHECK, S_DONE
  } state_t;

  state_t state;

  logic [chtqp_pkg::CFG_W-1:0] max_entries;
  logic [OCC_W-1:0]            occupancy;
  logic [IDX_W-1:0]            clr_idx;

  logic [1:0]                  req_type_q;
  logic [31:0]                 key_q;
  logic [chtqp_pkg::CNT_W-1:0] new_count_q;

  logic [IDX_W-1:0] h_lo;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] n;
  logic [IDX_W:0]   i;
  logic [IDX_W:0]   sq;

  logic [chtqp_pkg::CNT_W-1:0] res_count;
  logic                        res_new;
  logic [1:0]                  res_status;

  logic [31:0]       hash;
  chtqp_pkg::entry_t rd_entry;
  chtqp_pkg::entry_t wr_entry;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;

  logic [IDX_W:0]   i_next;
  logic [IDX_W:0]   sq_next;
  logic [IDX_W-1:0] slot_next;

  logic                        hit, empty, last, room, is_upd;
  logic                        chk_we, chk_done, chk_new;
  logic [chtqp_pkg::CNT_W-1:0] chk_count;
  logic [1:0]                  chk_status;

  chtqp_hash u_hash (
    .clk  (clk),
    .key  (key_q),
    .hash (hash)
  );

  chtqp_ram #(
    .DATA_W ($bits(chtqp_pkg::entry_t)),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_entry),
    .raddr (slot),
    .rdata (rd_entry)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    i_next    = i + 1'b1;
    sq_next   = sq + {i[IDX_W-1:0], 1'b1};
    slot_next = h_lo + i_next[IDX_W:1] + sq_next[IDX_W:1];

    hit    = rd_entry.valid && (rd_entry.key == key_q);
    empty  = !rd_entry.valid;
    last   = (n == '1);
    room   = (32'(occupancy) < 32'(max_entries));
    is_upd = (req_type_q == chtqp_pkg::REQ_INC) || (req_type_q == chtqp_pkg::REQ_SET);

    chk_done   = hit || empty || last;
    chk_we     = 1'b0;
    chk_new    = 1'b0;
    chk_count  = '0;
    chk_status = chtqp_pkg::ST_OK;
    wr_entry   = '{valid: 1'b1, key: key_q, count: new_count_q};

    if (hit) begin
      if (req_type_q == chtqp_pkg::REQ_INC) begin
        chk_we         = 1'b1;
        wr_entry.count = (rd_entry.count == '1) ? rd_entry.count : rd_entry.count + 1'b1;
      end else if (req_type_q == chtqp_pkg::REQ_SET) begin
        chk_we = 1'b1;
      end else begin
        wr_entry.count = rd_entry.count;
      end
      chk_count = wr_entry.count;
    end else if (empty && is_upd && room) begin
      chk_we  = 1'b1;
      chk_new = 1'b1;
      if (req_type_q == chtqp_pkg::REQ_INC) begin
        wr_entry.count = chtqp_pkg::CNT_W'(1);
      end
      chk_count = wr_entry.count;
    end else if ((empty || last) && is_upd) begin
      chk_status = chtqp_pkg::ST_FULL;
    end

    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      wr_entry  = '0;
    end else begin
      mem_we    = (state == S_CHECK) && chk_we;
      mem_waddr = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      occupancy   <= '0;
      max_entries <= chtqp_pkg::MAX_ENTRIES_RST;
      rsp.valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        max_entries <= cfg.max_entries;
      end
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            req_type_q  <= req.req_type;
            key_q       <= req.key;
            new_count_q <= req.new_count;
            if (req.key == '1) begin
              res_count  <= '0;
              res_new    <= 1'b0;
              res_status <= chtqp_pkg::ST_RESERVED;
              state      <= S_DONE;
            end else begin
              state <= S_MIX;
            end
          end
        end
        S_MIX: state <= S_MUL;
        S_MUL: state <= S_HASH;
        S_HASH: begin
          h_lo  <= hash[IDX_W-1:0];
          slot  <= hash[IDX_W-1:0];
          i     <= (IDX_W+1)'(1);
          sq    <= (IDX_W+1)'(1);
          n     <= '0;
          state <= S_READ;
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (chk_done) begin
            res_count  <= chk_count;
            res_new    <= chk_new;
            res_status <= chk_status;
            if (chk_new) begin
              occupancy <= occupancy + 1'b1;
            end
            state <= S_DONE;
          end else begin
            i     <= i_next;
            sq    <= sq_next;
            slot  <= slot_next;
            n     <= n + 1'b1;
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid     <= 1'b1;
            rsp.count_out <= res_count;
            rsp.is_new    <= res_new;
            rsp.status    <= res_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occupancy) <= chtqp_pkg::TABLE_SIZE)
    else $error("occupancy above table size");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && occupancy != $past(occupancy)) |->
      (occupancy == OCC_W'($past(occupancy) + 1'b1) && res_new))
    else $error("occupancy changed without an insert");

  a_reserved: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.key == '1) |=>
      (state == S_DONE && res_status == chtqp_pkg::ST_RESERVED))
    else $error("reserved key not rejected");

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("request taken during clearing pass");

  a_new_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_new) |-> (rsp.status == chtqp_pkg::ST_OK))
    else $error("insert reported with bad status");
`endif

endmodule
`default_nettype wire

FILE: verif/counting_hash_table_quadratic_probe_tb.sv
// Testbench for the counting hash table: predicts each response and checks it as it leaves.
module counting_hash_table_quadratic_probe_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_W = chtqp_pkg::KEY_W;
  localparam int CNT_W = chtqp_pkg::CNT_W;
  localparam int CFG_W = chtqp_pkg::CFG_W;
  localparam int IDX_W = chtqp_pkg::IDX_W;

  localparam logic [1:0]       REQ_SPARE     = 2'd3;
  localparam logic [KEY_W-1:0] RESERVED_KEY  = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] COUNT_TOP     = 32'hFFFF_FFFF;
  localparam int               CYCLE_LIMIT   = 2_000_000;
  localparam int               SETTLE_CYCLES = 64;
  localparam int               RANDOM_ITEMS  = 1830;
  localparam int               PHASES        = 6;
  localparam int               POOL_SIZE     = 48;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             is_new;
    logic [1:0]       status;
  } reply_t;

  typedef enum logic [1:0] {PROBE_MISS, PROBE_HIT, PROBE_EMPTY} probe_t;

  class key_tally;
    bit               used [chtqp_pkg::TABLE_SIZE];
    logic [KEY_W-1:0] keys [chtqp_pkg::TABLE_SIZE];
    logic [CNT_W-1:0] counts [chtqp_pkg::TABLE_SIZE];
    int unsigned      fill;
    logic [CFG_W-1:0] limit;
    reply_t           awaited [$];
    int unsigned      fault_count;

    function new();
      foreach (used[s]) used[s] = 1'b0;
      fill        = 0;
      limit       = chtqp_pkg::MAX_ENTRIES_RST;
      fault_count = 0;
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      limit = v;
    endfunction

    function logic [31:0] scramble(logic [31:0] a);
      logic [31:0] x;
      x = (a ^ chtqp_pkg::MIX_XOR) ^ (a >> 16);
      x = x + (x << 3);
      x = x ^ (x >> 4);
      x = x * chtqp_pkg::MIX_MUL;
      x = x ^ (x >> 15);
      return x;
    endfunction

    function probe_t locate_slot(logic [KEY_W-1:0] k, output logic [IDX_W-1:0] slot);
      logic [31:0] h;
      logic [31:0] i;
      logic [31:0] sq;
      logic [31:0] j;
      h    = scramble(k);
      j    = h;
      i    = 32'd1;
      slot = '0;
      for (int n = 0; n < chtqp_pkg::TABLE_SIZE; n++) begin
        if (n > 0) begin
          i  = i + 32'd1;
          sq = i * i;
          j  = h + (i >> 1) + (sq >> 1);
        end
        slot = j[IDX_W-1:0];
        if (!used[slot]) return PROBE_EMPTY;
        if (keys[slot] == k) return PROBE_HIT;
      end
      return PROBE_MISS;
    endfunction

    function void absorb_request(logic [1:0] op, logic [KEY_W-1:0] k, logic [CNT_W-1:0] val);
      reply_t           r;
      probe_t           found;
      logic [IDX_W-1:0] slot;
      r        = '0;
      r.status = chtqp_pkg::ST_OK;
      if (k == RESERVED_KEY) begin
        r.status = chtqp_pkg::ST_RESERVED;
      end else begin
        found = locate_slot(k, slot);
        if (op == chtqp_pkg::REQ_INC || op == chtqp_pkg::REQ_SET) begin
          if (found == PROBE_HIT) begin
            if (op == chtqp_pkg::REQ_INC) begin
              if (counts[slot] != COUNT_TOP) counts[slot] = counts[slot] + 1'b1;
            end else begin
              counts[slot] = val;
            end
            r.count = counts[slot];
          end else if (found == PROBE_EMPTY && fill < limit) begin
            used[slot]   = 1'b1;
            keys[slot]   = k;
            counts[slot] = (op == chtqp_pkg::REQ_INC) ? 32'd1 : val;
            fill++;
            r.count  = counts[slot];
            r.is_new = 1'b1;
          end else begin
            r.status = chtqp_pkg::ST_FULL;
          end
        end else if (found == PROBE_HIT) begin
          r.count = counts[slot];
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (awaited.size() == 0) begin
        $error("response with no request outstanding: count_out %0h is_new %0b status %0d",
               got.count, got.is_new, got.status);
        fault_count++;
        return;
      end
      want = awaited.pop_front();
      if (got.count !== want.count) begin
        $error("count_out: expected %0h, actual %0h", want.count, got.count);
        fault_count++;
      end
      if (got.is_new !== want.is_new) begin
        $error("is_new: expected %0b, actual %0b", want.is_new, got.is_new);
        fault_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fault_count++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned cycle_count = 0;
  logic [9:0]  stall_tick;
  key_tally    tally;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  chtqp_req_if req_ch ();
  chtqp_rsp_if rsp_ch ();
  chtqp_cfg_if cfg_ch ();

  counting_hash_table_quadratic_probe u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready)
        tally.check_reply(reply_t'({rsp_ch.count_out, rsp_ch.is_new, rsp_ch.status}));
      if (req_ch.valid && req_ch.ready)
        tally.absorb_request(req_ch.req_type, req_ch.key, req_ch.new_count);
      if (cfg_ch.valid && cfg_ch.ready)
        tally.set_limit(cfg_ch.max_entries);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("counting_hash_table_quadratic_probe: mismatch");
      $finish;
    end
  end

  // response stalls: mode set by stall_tick[9:8]
  initial begin
    rsp_ch.ready = 1'b0;
    stall_tick   = '0;
    forever begin
      @(negedge clk);
      stall_tick = stall_tick + 1'b1;
      case (stall_tick[9:8])
        2'd0: rsp_ch.ready = 1'b1;
        2'd1: rsp_ch.ready = 1'($urandom_range(0, 1));
        2'd2: rsp_ch.ready = (stall_tick[2:0] != 3'd0);
        default: rsp_ch.ready = stall_tick[3];
      endcase
    end
  end

  task automatic push_request(logic [1:0] op, logic [KEY_W-1:0] k, logic [CNT_W-1:0] val);
    @(negedge clk);
    req_ch.valid     = 1'b1;
    req_ch.req_type  = op;
    req_ch.key       = k;
    req_ch.new_count = val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic hold_off(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (tally.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid       = 1'b1;
    cfg_ch.max_entries = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin
    int unsigned      burst;
    int unsigned      left;
    int unsigned      pick;
    logic [CFG_W-1:0] cap;
    logic [1:0]       op;
    logic [KEY_W-1:0] k;
    logic [CNT_W-1:0] val;
    tally              = new();
    req_ch.valid       = 1'b0;
    req_ch.req_type    = chtqp_pkg::REQ_INC;
    req_ch.key         = '0;
    req_ch.new_count   = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.max_entries = chtqp_pkg::MAX_ENTRIES_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // limit of one entry: full refusals, saturation, reserved key, spare selector
    write_limit(13'd1);
    push_request(chtqp_pkg::REQ_QUERY, 32'h1234_5678, 32'd0);
    push_request(chtqp_pkg::REQ_INC,   32'h0000_0000, 32'd0);
    push_request(chtqp_pkg::REQ_INC,   32'h7FFF_FFFF, 32'd0);
    push_request(chtqp_pkg::REQ_SET,   32'h7FFF_FFFF, 32'd5);
    push_request(chtqp_pkg::REQ_INC,   32'h0000_0000, 32'hFFFF_FFFF);
    push_request(chtqp_pkg::REQ_SET,   32'h0000_0000, COUNT_TOP - 1'b1);
    push_request(chtqp_pkg::REQ_INC,   32'h0000_0000, 32'd0);
    push_request(chtqp_pkg::REQ_INC,   32'h0000_0000, 32'd0);
    push_request(chtqp_pkg::REQ_QUERY, 32'h0000_0000, 32'd0);
    push_request(REQ_SPARE,            32'h0000_0000, 32'hFFFF_FFFF);
    push_request(REQ_SPARE,            32'h7FFF_FFFF, 32'd7);
    push_request(chtqp_pkg::REQ_INC,   RESERVED_KEY,  32'd1);
    push_request(chtqp_pkg::REQ_SET,   RESERVED_KEY,  32'hFFFF_FFFF);
    push_request(chtqp_pkg::REQ_QUERY, RESERVED_KEY,  32'd0);
    push_request(REQ_SPARE,            RESERVED_KEY,  32'd0);
    push_request(chtqp_pkg::REQ_SET,   32'h0000_0000, 32'd0);
    push_request(chtqp_pkg::REQ_QUERY, 32'h7FFF_FFFF, 32'd0);
    push_request(chtqp_pkg::REQ_QUERY, 32'h8000_0000, 32'd0);
    drain();

    // limit of three: set inserts a new key at the count ceiling
    write_limit(13'd3);
    push_request(chtqp_pkg::REQ_SET,   32'h8000_0000, COUNT_TOP);
    push_request(chtqp_pkg::REQ_INC,   32'h8000_0000, 32'd0);
    push_request(chtqp_pkg::REQ_INC,   32'h7FFF_FFFF, 32'd0);
    push_request(chtqp_pkg::REQ_INC,   32'h5555_5555, 32'd0);
    push_request(chtqp_pkg::REQ_QUERY, 32'h8000_0000, 32'd0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: cap = CFG_W'(chtqp_pkg::TABLE_SIZE);
        1: cap = CFG_W'(tally.fill + $urandom_range(1, 20));
        2: cap = 13'd4095;
        3: cap = 13'd1;
        4: cap = CFG_W'($urandom_range(1, chtqp_pkg::TABLE_SIZE));
        default: cap = chtqp_pkg::MAX_ENTRIES_RST;
      endcase
      write_limit(cap);
      foreach (key_pool[p]) key_pool[p] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFE;
      left = RANDOM_ITEMS / PHASES;
      while (left > 0) begin
        burst = $urandom_range(1, 16);
        if (burst > left) burst = left;
        repeat (burst) begin
          pick = $urandom_range(0, 99);
          if (pick < 40)      op = chtqp_pkg::REQ_INC;
          else if (pick < 62) op = chtqp_pkg::REQ_SET;
          else if (pick < 94) op = chtqp_pkg::REQ_QUERY;
          else                op = REQ_SPARE;
          pick = $urandom_range(0, 99);
          if (pick < 60)      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
          else if (pick < 85) k = $urandom;
          else if (pick < 95) k = $urandom_range(0, 15);
          else                k = RESERVED_KEY;
          pick = $urandom_range(0, 9);
          if (pick == 0)      val = COUNT_TOP;
          else if (pick == 1) val = COUNT_TOP - 1'b1;
          else if (pick == 2) val = '0;
          else                val = $urandom;
          push_request(op, k, val);
        end
        left = left - burst;
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tally.awaited.size() != 0) begin
      $error("%0d expected responses never arrived", tally.awaited.size());
      tally.fault_count++;
    end
    if (tally.fault_count == 0) begin
      $display("counting_hash_table_quadratic_probe: match");
    end else begin
      $display("counting_hash_table_quadratic_probe: mismatch");
    end
    $finish;
  end

endmodule
